[src/cdss_pkg.sv]
// Package for the countdown seven-segment scanner.
// Holds the display tables, register indexes and fixed widths; no dependencies.
package cdss_pkg;

  localparam int unsigned Digits     = 4;
  localparam int unsigned DivW       = 8;
  localparam int unsigned CountW     = 14;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned DigitW     = 5;
  localparam int unsigned IdxW       = $clog2(Digits);
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 14;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegTickDivide = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWrapValue  = 1'd1;

  localparam logic [DivW-1:0]   TickDivideReset = 8'd10;
  localparam logic [CountW-1:0] WrapValueReset  = 14'd9999;
  localparam logic [CountW-1:0] CountReset      = 14'd9999;

  localparam logic [ByteW-1:0] BlankPattern = 8'h00;

  typedef logic [ByteW-1:0] byte_t;

  // Digit-select byte, thousands first.
  localparam byte_t SelectTab [Digits] = '{8'hF1, 8'hF2, 8'hF4, 8'hF8};

  // Segment bytes for decimal digits zero to nine.
  localparam byte_t SegTab [10] = '{
    8'hA0, 8'hBB, 8'h62, 8'h2A, 8'h39, 8'h2C, 8'h25, 8'hBA, 8'h20, 8'h38
  };

endpackage

[src/countdown_seven_segment_scanner.sv]
// Top level of the countdown seven-segment scanner.
// Depends on cdss_pkg for tables, register indexes and widths.
//
// Usage: every item on the input channel is one timer tick that carries
// count_enable_i. An 8-bit prescaler steps on each tick and returns to zero
// when it matches tick_divide; on that tick an enabled item decrements the
// decimal count, which reloads wrap_value from zero. Each tick then yields one
// result item with the digit-select byte for digit (prescale mod 4), the
// segment byte of that decimal digit of the count, and the count itself.
// Digit positions run thousands, hundreds, tens, ones; a thousands digit above
// nine shows a blank pattern.
// One item is accepted every cycle while in_stall_o is low. The first stage
// updates the prescaler and count; the second splits the count into decimal
// digits by a short chain of constant compares and reads the segment table.
// The configuration port takes one register write per cycle and is always
// ready: index 0 writes tick_divide, index 1 writes wrap_value.
// Reset sets tick_divide to 10, wrap_value and the count to 9999 and the
// prescaler to zero, and empties the pipeline.
// When the receiver stalls, the result item holds; the input keeps being
// accepted until the middle stage is also full, then in_stall_o rises.
module countdown_seven_segment_scanner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           count_enable_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cdss_pkg::ByteW-1:0]     digit_select_o,
  output logic [cdss_pkg::ByteW-1:0]     segment_pattern_o,
  output logic [cdss_pkg::CountW-1:0]    count_value_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cdss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cdss_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cdss_pkg::*;

  // Configuration registers.
  logic [DivW-1:0]   tick_divide_q;
  logic [CountW-1:0] wrap_value_q;

  // Block state.
  logic [DivW-1:0]   prescale_q, prescale_d;
  logic [CountW-1:0] count_q, count_d;

  // Middle stage: digit index and count after the tick.
  logic              mid_valid_q, mid_valid_d;
  logic [IdxW-1:0]   mid_idx_q;
  logic [CountW-1:0] mid_count_q;

  // Result stage.
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  sel_q, seg_q;
  logic [CountW-1:0] out_count_q;

  logic in_accept, out_hold, mid_advance;
  logic [DivW-1:0] prescale_inc;

  // Handshake: the result register holds while stalled; the middle stage
  // moves forward whenever the result register is free or being taken.
  assign out_hold    = out_valid_q & out_stall_i;
  assign mid_advance = mid_valid_q & ~out_hold;
  assign in_stall_o  = mid_valid_q & out_hold;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign mid_valid_d = in_accept | (mid_valid_q & out_hold);
  assign out_valid_d = mid_advance | out_hold;
  assign cfg_ready_o = 1'b1;

  // Prescaler and count update for one tick.
  assign prescale_inc = prescale_q + 1'b1;

  always_comb begin
    prescale_d = prescale_inc;
    count_d    = count_q;
    if (prescale_inc == tick_divide_q) begin
      prescale_d = '0;
      if (count_enable_i) begin
        count_d = (count_q == '0) ? wrap_value_q : count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_divide_q <= TickDivideReset;
      wrap_value_q  <= WrapValueReset;
      prescale_q    <= '0;
      count_q       <= CountReset;
      mid_valid_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegTickDivide: tick_divide_q <= cfg_data_i[DivW-1:0];
          RegWrapValue:  wrap_value_q  <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        prescale_q <= prescale_d;
        count_q    <= count_d;
      end
      mid_valid_q <= mid_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mid_idx_q   <= prescale_d[IdxW-1:0];
      mid_count_q <= count_d;
    end
  end

  // Decimal digits of the middle-stage count. Each position is a set of
  // independent compares against constant multiples followed by one subtract.
  logic [DigitW-1:0] dig_thou, dig_hund, dig_tens, dig_ones, dig_sel;
  logic [9:0]        rem_thou;
  logic [6:0]        rem_hund;
  logic [3:0]        rem_tens;
  logic [ByteW-1:0]  seg_d;

  always_comb begin
    dig_thou = '0;
    rem_thou = mid_count_q[9:0];
    for (int k = 1; k <= 16; k++) begin
      if (mid_count_q >= CountW'(k * 1000)) begin
        dig_thou = DigitW'(k);
        rem_thou = 10'(mid_count_q - CountW'(k * 1000));
      end
    end
    dig_hund = '0;
    rem_hund = rem_thou[6:0];
    for (int k = 1; k <= 9; k++) begin
      if (rem_thou >= 10'(k * 100)) begin
        dig_hund = DigitW'(k);
        rem_hund = 7'(rem_thou - 10'(k * 100));
      end
    end
    dig_tens = '0;
    rem_tens = rem_hund[3:0];
    for (int k = 1; k <= 9; k++) begin
      if (rem_hund >= 7'(k * 10)) begin
        dig_tens = DigitW'(k);
        rem_tens = 4'(rem_hund - 7'(k * 10));
      end
    end
    dig_ones = DigitW'(rem_tens);

    unique case (mid_idx_q)
      2'd0:    dig_sel = dig_thou;
      2'd1:    dig_sel = dig_hund;
      2'd2:    dig_sel = dig_tens;
      default: dig_sel = dig_ones;
    endcase

    // A thousands digit above nine, from a large wrap value, shows blank.
    seg_d = (dig_sel < DigitW'(10)) ? SegTab[dig_sel[3:0]] : BlankPattern;
  end

  always_ff @(posedge clk_i) begin
    if (mid_advance) begin
      sel_q       <= SelectTab[mid_idx_q];
      seg_q       <= seg_d;
      out_count_q <= mid_count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign digit_select_o    = sel_q;
  assign segment_pattern_o = seg_q;
  assign count_value_o     = out_count_q;

endmodule

[src/cdss_checker.sv]
// Port-level checks for the countdown seven-segment scanner.
// Depends on cdss_pkg; bound to countdown_seven_segment_scanner below.
module cdss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [cdss_pkg::ByteW-1:0]    digit_select_o,
  input logic [cdss_pkg::ByteW-1:0]    segment_pattern_o,
  input logic [cdss_pkg::CountW-1:0]   count_value_o
);
  import cdss_pkg::*;

  // A stalled result item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_select_o)
      && $stable(segment_pattern_o) && $stable(count_value_o))
    else $error("stalled result item changed");

  // Exactly one digit is selected, with the upper nibble high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_select_o == 8'hF1 || digit_select_o == 8'hF2
      || digit_select_o == 8'hF4 || digit_select_o == 8'hF8)
    else $error("bad digit select");

  // A blank pattern only appears on the thousands digit of a large count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && segment_pattern_o == BlankPattern
      |-> count_value_o >= 14'd10000 && digit_select_o == 8'hF1)
    else $error("blank pattern on a decimal digit");

  // Counts below ten thousand never blank the thousands digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_value_o < 14'd10000 && digit_select_o == 8'hF1
      |-> segment_pattern_o != BlankPattern)
    else $error("thousands digit blanked");

endmodule

bind countdown_seven_segment_scanner cdss_checker u_cdss_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .digit_select_o    (digit_select_o),
  .segment_pattern_o (segment_pattern_o),
  .count_value_o     (count_value_o)
);

[dv/tb_top.sv]
// Testbench for the countdown seven-segment scanner: directed table, then random ticks.
// Depends on cdss_pkg and countdown_seven_segment_scanner; results are checked in order.
`timescale 1ns / 100ps

module tb_top;
  import cdss_pkg::*;

  // One displayed result: digit-select byte, segment byte and the count.
  typedef struct packed {
    logic [ByteW-1:0]  sel;
    logic [ByteW-1:0]  seg;
    logic [CountW-1:0] count;
  } scan_result_t;

  typedef enum logic {RowTick, RowWrite} row_kind_t;

  // A row of the directed table is either a tick or a register write.
  // Ticks marked known carry an expected result that is obvious by inspection.
  typedef struct packed {
    row_kind_t            kind;
    logic                 en;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  value;
    logic                 known;
    scan_result_t         res;
  } dir_row_t;

  localparam int unsigned DirRowCount = 23;

  // Right after reset the divide is 10 and the count 9999, so the first ticks
  // scan digits 1, 2, 3 and 0, all showing a nine. The tenth tick steps the count.
  localparam dir_row_t DirRows [DirRowCount] = '{
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b1, '{8'hF2, 8'h38, 14'd9999}},
    '{RowTick,  1'b0, RegTickDivide, 14'd0,     1'b1, '{8'hF4, 8'h38, 14'd9999}},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b1, '{8'hF8, 8'h38, 14'd9999}},
    '{RowTick,  1'b0, RegTickDivide, 14'd0,     1'b1, '{8'hF1, 8'h38, 14'd9999}},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b0, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b0, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b1, '{8'hF1, 8'h38, 14'd9998}},
    '{RowTick,  1'b0, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b0, '0},
    // Largest divide.
    '{RowWrite, 1'b0, RegTickDivide, 14'd255,   1'b0, '0},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b0, RegTickDivide, 14'd0,     1'b0, '0},
    // A divide of zero makes the prescaler run the full 256 ticks.
    '{RowWrite, 1'b0, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowWrite, 1'b0, RegWrapValue,  14'd9999,  1'b0, '0},
    '{RowWrite, 1'b0, RegWrapValue,  14'd16383, 1'b0, '0},
    '{RowWrite, 1'b0, RegWrapValue,  14'd0,     1'b0, '0},
    // The divide drops below the running prescaler, which must wrap through 255.
    '{RowWrite, 1'b0, RegTickDivide, 14'd1,     1'b0, '0},
    '{RowTick,  1'b1, RegTickDivide, 14'd0,     1'b0, '0},
    '{RowTick,  1'b0, RegTickDivide, 14'd0,     1'b0, '0}
  };

  // Display tables of the scanner, thousands digit first.
  localparam logic [ByteW-1:0] SelByte [4] = '{8'hF1, 8'hF2, 8'hF4, 8'hF8};
  localparam logic [ByteW-1:0] SegByte [10] = '{
    8'hA0, 8'hBB, 8'h62, 8'h2A, 8'h39, 8'h2C, 8'h25, 8'hBA, 8'h20, 8'h38
  };

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 count_enable_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b1;
  logic [ByteW-1:0]     digit_select_o;
  logic [ByteW-1:0]     segment_pattern_o;
  logic [CountW-1:0]    count_value_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i    = '0;
  logic [CfgDataW-1:0]  cfg_data_i     = '0;

  // Shadow state of the scanner as the testbench expects it.
  logic [DivW-1:0]   prescale_q = '0;
  logic [CountW-1:0] count_q    = CountReset;
  logic [DivW-1:0]   divide_reg = TickDivideReset;
  logic [CountW-1:0] wrap_reg   = WrapValueReset;

  scan_result_t pending_scans [$];
  int unsigned  mismatches = 0;

  // When set, the sender or the receiver runs without any idle cycles.
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  always #5 clk_i = ~clk_i;

  countdown_seven_segment_scanner dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .count_enable_i    (count_enable_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .digit_select_o    (digit_select_o),
    .segment_pattern_o (segment_pattern_o),
    .count_value_o     (count_value_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Advances the shadow state by one tick and returns the result it displays.
  // The prescaler is 8 bits, so with a divide below its value it wraps through
  // 255 before it matches, and a divide of zero matches on the wrap itself.
  function automatic scan_result_t scan_tick(input logic en);
    scan_result_t      res;
    logic [DigitW-1:0] digit;
    prescale_q = prescale_q + 1'b1;
    if (prescale_q == divide_reg) begin
      if (en) begin
        count_q = (count_q == '0) ? wrap_reg : count_q - 1'b1;
      end
      prescale_q = '0;
    end
    case (prescale_q[1:0])
      2'd0:    digit = DigitW'(count_q / 1000);
      2'd1:    digit = DigitW'((count_q / 100) % 10);
      2'd2:    digit = DigitW'((count_q / 10) % 10);
      default: digit = DigitW'(count_q % 10);
    endcase
    res.sel   = SelByte[prescale_q[1:0]];
    // A count above 9999 gives a thousands digit above nine, which shows blank.
    res.seg   = (digit < DigitW'(10)) ? SegByte[digit[3:0]] : BlankPattern;
    res.count = count_q;
    return res;
  endfunction

  // Offers one tick after a random gap and records its expected result on
  // acceptance. Valid stays high after acceptance so back-to-back items need
  // no second assignment in the same step.
  task automatic send_tick(input logic en, input logic known, input scan_result_t known_res);
    int unsigned  gap;
    scan_result_t res;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    count_enable_i <= en;
    do @(posedge clk_i); while (in_stall_o);
    res = scan_tick(en);
    pending_scans.push_back(known ? known_res : res);
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic drain_results();
    if (pending_scans.size() != 0) begin
      in_valid_i <= 1'b0;
      while (pending_scans.size() != 0) @(posedge clk_i);
    end
  endtask

  // Writes one register; valid is held across a run of writes and dropped
  // after the last one.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val,
                           input logic last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegTickDivide) begin
      divide_reg = val[DivW-1:0];
    end else begin
      wrap_reg = val[CountW-1:0];
    end
    if (last) begin
      cfg_valid_i <= 1'b0;
    end
  endtask

  // Receiver: takes results, compares them with the oldest expectation, then
  // stalls for a random number of cycles before it takes the next one.
  always @(posedge clk_i) begin : result_side
    int unsigned  hold;
    int unsigned  stall_left;
    scan_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      stall_left  = 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (pending_scans.size() == 0) begin
        $error("result item with no expectation: sel %h seg %h count %0d",
               digit_select_o, segment_pattern_o, count_value_o);
        mismatches++;
      end else begin
        want = pending_scans.pop_front();
        if (digit_select_o !== want.sel) begin
          $error("digit_select: expected %h, actual %h", want.sel, digit_select_o);
          mismatches++;
        end
        if (segment_pattern_o !== want.seg) begin
          $error("segment_pattern: expected %h, actual %h", want.seg, segment_pattern_o);
          mismatches++;
        end
        if (count_value_o !== want.count) begin
          $error("count_value: expected %0d, actual %0d", want.count, count_value_o);
          mismatches++;
        end
      end
      hold        = rx_burst ? 0 : $urandom_range(0, 19);
      stall_left  = hold;
      out_stall_i <= (hold != 0);
    end else begin
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  initial begin : stimulus
    dir_row_t          row;
    logic              last;
    logic              prev_tick;
    logic [DivW-1:0]   div;
    logic [CountW-1:0] wrap;
    int unsigned       len;
    int unsigned       random_ticks;
    int unsigned       waited;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A write waits until the block has no result in flight.
    prev_tick = 1'b0;
    for (int r = 0; r < DirRowCount; r++) begin
      row = DirRows[r];
      if (row.kind == RowWrite) begin
        if (prev_tick) begin
          drain_results();
        end
        last = (r == DirRowCount - 1) || (DirRows[r + 1].kind != RowWrite);
        write_reg(row.idx, row.value, last);
        prev_tick = 1'b0;
      end else begin
        send_tick(row.en, row.known, row.res);
        prev_tick = 1'b1;
      end
    end

    // Burst at divide 1 with no idling on either side. This finishes the
    // wrap-through of the prescaler from the table and then steps the count
    // on nearly every tick.
    tx_burst = 1'b1;
    rx_burst <= 1'b1;
    repeat (260) send_tick(($urandom_range(0, 15) != 0), 1'b0, '0);

    // Random phases with fresh divide and wrap values; divides of 0 and 255
    // get long phases so that the count still steps.
    random_ticks = 0;
    while (random_ticks < 780) begin
      case ($urandom_range(0, 9))
        0:       div = '0;
        1:       div = 8'd255;
        2:       div = DivW'($urandom_range(1, 255));
        default: div = DivW'($urandom_range(1, 6));
      endcase
      wrap = ($urandom_range(0, 3) == 0) ? '0 : CountW'($urandom_range(1, 40));
      len  = (div == '0 || div == 8'd255) ? 300 : $urandom_range(40, 120);
      if (len > 780 - random_ticks) begin
        len = 780 - random_ticks;
      end
      drain_results();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst <= ($urandom_range(0, 3) == 0);
      write_reg(RegTickDivide, CfgDataW'(div), 1'b0);
      write_reg(RegWrapValue, wrap, 1'b1);
      repeat (len) begin
        // Now and then hold off until the pipeline is empty.
        if ($urandom_range(0, 63) == 0) begin
          drain_results();
        end
        send_tick(($urandom_range(0, 3) != 0), 1'b0, '0);
        random_ticks++;
      end
    end

    // Wait for the outstanding results, then a few more cycles for strays.
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_scans.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_scans.size() != 0) begin
      $error("%0d expected results never arrived", pending_scans.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $error("run timed out");
    $display("status: fail");
    $finish;
  end

endmodule
